### hw/rtl/lcvg_pkg.sv
package lcvg_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_SQRT,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef enum logic [4:0] {
      OP_DIFF,
      OP_SQX,
      OP_SQY,
      OP_RAD,
      OP_DIVX,
      OP_DIVY,
      OP_CY,
      OP_KR,
      OP_RDOT,
      OP_VX0,
      OP_VX1,
      OP_VY0,
      OP_VY1,
      OP_VZ,
      OP_NX,
      OP_NY,
      OP_NZ,
      OP_NORM,
      OP_CLIP0,
      OP_CLIPM,
      OP_CLIPD,
      OP_CLIPW,
      OP_NEXT,
      OP_BL0,
      OP_BL1,
      OP_BL2,
      OP_BL3,
      OP_BL4
   } step_type;

   typedef enum logic [2:0] {
      REG_CYCLE_RADIUS,
      REG_CONVERGENCE_GAIN,
      REG_ANGULAR_SPEED,
      REG_VELOCITY_LIMIT,
      REG_BLEND_ALPHA,
      REG_TIME_STEP,
      REG_VELOCITY_MODE,
      REG_UNUSED
   } reg_index_type;

   localparam logic [23:0] TIME_STEP_RESET = 24'd16777;
   localparam logic [16:0] ALPHA_ONE       = 17'd65536;

   function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
      logic signed [31:0] r;
      if (v > 70'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -70'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] abs32(input logic signed [31:0] v);
      logic [31:0] r;
      r = v[31] ? 32'(-v) : 32'(v);
      return r;
   endfunction

endpackage

### hw/rtl/limit_cycle_velocity_generator_top.sv
// Limit-cycle velocity generator. Each req transfer carries a measured position, the cycle
// center and an object velocity; the block evaluates the polar limit-cycle law twice (at the
// selected pose and at the desired pose), clips both vectors to velocity_limit by their norm,
// advances the desired pose and returns the clipped first velocity and the new pose as one
// rsp transfer. All arithmetic runs through one 34x34 multiplier, one bit-serial square root
// and one restoring divider under a step sequencer. Each vector that exceeds the limit adds
// three divisions, and each evaluation that sees a zero radius skips both direction
// divisions. A result held back by rsp_tready stalls the block in its finish state.
// req_tready is high only between items. A finished result sits in the rsp register while
// the next item is taken. The first item after reset seeds the desired pose from the
// measured position.
module limit_cycle_velocity_generator_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // meas_x, meas_y, meas_z, center_x, center_y, center_z, obj_vel_x, obj_vel_y, obj_vel_z
   input  logic [287:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // vel_x, vel_y, vel_z, pose_x, pose_y, pose_z
   output logic [191:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [23:0]  csr_data
);

   lcvg_pkg::state_type state_ff, state_in;
   lcvg_pkg::step_type  step_ff, step_in;

   logic [23:0] radius_ff, gain_ff, omega_ff, limit_ff, dt_ff;
   logic [16:0] alpha_ff;
   logic        mode_ff;

   logic signed [31:0] meas_ff [3];
   logic signed [31:0] cen_ff  [3];
   logic signed [31:0] ov_ff   [3];
   logic signed [31:0] pose_ff [3];
   logic signed [31:0] pose_in [3];
   logic signed [31:0] d_ff    [3];
   logic signed [31:0] d_in    [3];
   logic signed [31:0] vc_ff   [3];
   logic signed [31:0] vc_in   [3];
   logic signed [31:0] v1_ff   [3];
   logic signed [31:0] v1_in   [3];
   logic signed [31:0] v2_ff   [3];
   logic signed [31:0] v2_in   [3];
   logic               seeded_ff, seeded_in;
   logic               pass_ff, pass_in;
   logic [1:0]         ax_ff, ax_in;
   logic [5:0]         iter_ff, iter_in;

   logic signed [31:0] cx_ff, cx_in, cy_ff, cy_in, rdot_ff, rdot_in;
   logic signed [32:0] b_ff, b_in;
   logic signed [65:0] acc_ff, acc_in;

   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] prod_ff;

   logic [63:0] sq_n_ff, sq_n_in, sq_res_ff, sq_res_in, sq_bit_ff, sq_bit_in;
   logic [32:0] dv_rem_ff, dv_rem_in;
   logic [63:0] dv_quo_ff, dv_quo_in;
   logic [31:0] dv_den_ff, dv_den_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [191:0] rsp_data_ff, rsp_data_in;

   logic        req_fire, out_free;
   logic [31:0] root;
   logic [31:0] quo;
   logic [16:0] alpha_eff;
   logic [64:0] sq_try;
   logic [32:0] dv_try;
   logic        launch_div_x;
   logic        clip_needed;

   assign req_tready = (state_ff == lcvg_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign root       = sq_res_ff[31:0];
   assign quo        = dv_quo_ff[31:0];
   assign alpha_eff  = (alpha_ff > lcvg_pkg::ALPHA_ONE) ? lcvg_pkg::ALPHA_ONE : alpha_ff;
   assign sq_try     = {1'b0, sq_res_ff} + {1'b0, sq_bit_ff};
   assign dv_try     = {dv_rem_ff[31:0], dv_quo_ff[63]};
   assign launch_div_x = (root != 32'd0);
   assign clip_needed  = (root > {8'd0, limit_ff});

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
         gain_ff   <= '0;
         omega_ff  <= '0;
         limit_ff  <= '0;
         alpha_ff  <= '0;
         dt_ff     <= lcvg_pkg::TIME_STEP_RESET;
         mode_ff   <= 1'b0;
      end else if (csr_valid) begin
         unique case (lcvg_pkg::reg_index_type'(csr_index))
            lcvg_pkg::REG_CYCLE_RADIUS:     radius_ff <= csr_data;
            lcvg_pkg::REG_CONVERGENCE_GAIN: gain_ff   <= csr_data;
            lcvg_pkg::REG_ANGULAR_SPEED:    omega_ff  <= csr_data;
            lcvg_pkg::REG_VELOCITY_LIMIT:   limit_ff  <= csr_data;
            lcvg_pkg::REG_BLEND_ALPHA:      alpha_ff  <= csr_data[16:0];
            lcvg_pkg::REG_TIME_STEP:        dt_ff     <= csr_data;
            lcvg_pkg::REG_VELOCITY_MODE:    mode_ff   <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lcvg_pkg::ST_IDLE: begin
            if (req_fire) state_in = lcvg_pkg::ST_RUN;
         end
         lcvg_pkg::ST_RUN: begin
            if (step_ff == lcvg_pkg::OP_RAD || step_ff == lcvg_pkg::OP_NORM) begin
               state_in = lcvg_pkg::ST_SQRT;
            end else if ((step_ff == lcvg_pkg::OP_DIVX && launch_div_x) ||
                         step_ff == lcvg_pkg::OP_DIVY || step_ff == lcvg_pkg::OP_CLIPD) begin
               state_in = lcvg_pkg::ST_DIV;
            end else if (step_ff == lcvg_pkg::OP_BL4 && ax_ff == 2'd2) begin
               state_in = lcvg_pkg::ST_FINISH;
            end
         end
         lcvg_pkg::ST_SQRT, lcvg_pkg::ST_DIV: begin
            if (iter_ff == 6'd0) state_in = lcvg_pkg::ST_RUN;
         end
         lcvg_pkg::ST_FINISH: begin
            if (out_free) state_in = lcvg_pkg::ST_IDLE;
         end
         default: state_in = lcvg_pkg::ST_IDLE;
      endcase
   end

   // Multiplier operand selection by sequencer step.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         lcvg_pkg::OP_SQX: begin
            mul_a = 34'(d_ff[0]);
            mul_b = 34'(d_ff[0]);
         end
         lcvg_pkg::OP_SQY: begin
            mul_a = 34'(d_ff[1]);
            mul_b = 34'(d_ff[1]);
         end
         lcvg_pkg::OP_KR: begin
            mul_a = $signed({10'd0, gain_ff});
            mul_b = $signed({2'd0, root}) - $signed({10'd0, radius_ff});
         end
         lcvg_pkg::OP_RDOT: begin
            mul_a = 34'($signed(omega_ff));
            mul_b = 34'(d_ff[1]);
         end
         lcvg_pkg::OP_VX0: begin
            mul_a = 34'(rdot_ff);
            mul_b = 34'(cx_ff);
         end
         lcvg_pkg::OP_VX1: begin
            mul_a = 34'($signed(omega_ff));
            mul_b = 34'(d_ff[0]);
         end
         lcvg_pkg::OP_VY0: begin
            mul_a = 34'(rdot_ff);
            mul_b = 34'(cy_ff);
         end
         lcvg_pkg::OP_VY1: begin
            mul_a = $signed({10'd0, gain_ff});
            mul_b = 34'(d_ff[2]);
         end
         lcvg_pkg::OP_NX: begin
            mul_a = 34'(vc_ff[0]);
            mul_b = 34'(vc_ff[0]);
         end
         lcvg_pkg::OP_NY: begin
            mul_a = 34'(vc_ff[1]);
            mul_b = 34'(vc_ff[1]);
         end
         lcvg_pkg::OP_NZ: begin
            mul_a = 34'(vc_ff[2]);
            mul_b = 34'(vc_ff[2]);
         end
         lcvg_pkg::OP_CLIPM: begin
            mul_a = $signed({2'd0, lcvg_pkg::abs32(vc_ff[ax_ff])});
            mul_b = $signed({10'd0, limit_ff});
         end
         lcvg_pkg::OP_BL0: begin
            mul_a = $signed({17'd0, lcvg_pkg::ALPHA_ONE - alpha_eff});
            mul_b = 34'(v1_ff[ax_ff]);
         end
         lcvg_pkg::OP_BL1: begin
            mul_a = $signed({17'd0, alpha_eff});
            mul_b = 34'(v2_ff[ax_ff]);
         end
         lcvg_pkg::OP_BL3: begin
            mul_a = 34'(b_ff);
            mul_b = $signed({10'd0, dt_ff});
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // Datapath and sequencer step.
   always_comb begin
      logic signed [31:0] p_sel [3];
      logic signed [31:0] q_signed;
      step_in   = step_ff;
      seeded_in = seeded_ff;
      pass_in   = pass_ff;
      ax_in     = ax_ff;
      iter_in   = iter_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      rdot_in   = rdot_ff;
      b_in      = b_ff;
      acc_in    = acc_ff;
      sq_n_in   = sq_n_ff;
      sq_res_in = sq_res_ff;
      sq_bit_in = sq_bit_ff;
      dv_rem_in = dv_rem_ff;
      dv_quo_in = dv_quo_ff;
      dv_den_in = dv_den_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      q_signed = dv_quo_ff[31] ? 32'sh7FFFFFFF : $signed(quo);
      for (int i = 0; i < 3; i++) begin
         pose_in[i] = pose_ff[i];
         d_in[i]    = d_ff[i];
         vc_in[i]   = vc_ff[i];
         v1_in[i]   = v1_ff[i];
         v2_in[i]   = v2_ff[i];
         p_sel[i]   = (!pass_ff && mode_ff) ? meas_ff[i] : pose_ff[i];
      end

      unique case (state_ff)
         lcvg_pkg::ST_IDLE: begin
            if (req_fire) begin
               step_in = lcvg_pkg::OP_DIFF;
               pass_in = 1'b0;
               ax_in   = 2'd0;
               if (!seeded_ff) begin
                  seeded_in = 1'b1;
                  for (int i = 0; i < 3; i++) begin
                     pose_in[i] = $signed(req_tdata[32*i +: 32]);
                  end
               end
            end
         end
         lcvg_pkg::ST_SQRT: begin
            if ({1'b0, sq_n_ff} >= sq_try) begin
               sq_n_in   = sq_n_ff - sq_try[63:0];
               sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_in = sq_res_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            iter_in   = iter_ff - 6'd1;
         end
         lcvg_pkg::ST_DIV: begin
            if (dv_try >= {1'b0, dv_den_ff}) begin
               dv_rem_in = dv_try - {1'b0, dv_den_ff};
               dv_quo_in = {dv_quo_ff[62:0], 1'b1};
            end else begin
               dv_rem_in = dv_try;
               dv_quo_in = {dv_quo_ff[62:0], 1'b0};
            end
            iter_in = iter_ff - 6'd1;
         end
         lcvg_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               for (int i = 0; i < 3; i++) begin
                  rsp_data_in[32*i +: 32]      = v1_ff[i];
                  rsp_data_in[96 + 32*i +: 32] = pose_ff[i];
               end
            end
         end
         lcvg_pkg::ST_RUN: begin
            step_in = lcvg_pkg::step_type'(step_ff + 5'd1);
            case (step_ff)
               lcvg_pkg::OP_DIFF: begin
                  for (int i = 0; i < 3; i++) begin
                     d_in[i] = lcvg_pkg::sat32(70'(p_sel[i]) - 70'(cen_ff[i]));
                  end
               end
               lcvg_pkg::OP_SQY: acc_in = 66'(prod_ff);
               lcvg_pkg::OP_RAD, lcvg_pkg::OP_NORM: begin
                  sq_n_in   = 64'(acc_ff + 66'(prod_ff));
                  sq_res_in = '0;
                  sq_bit_in = 64'd1 << 62;
                  iter_in   = 6'd31;
               end
               lcvg_pkg::OP_DIVX: begin
                  if (launch_div_x) begin
                     dv_quo_in = {2'd0, lcvg_pkg::abs32(d_ff[0]), 30'd0};
                     dv_rem_in = '0;
                     dv_den_in = root;
                     iter_in   = 6'd63;
                  end else begin
                     // Zero radius: the angle is taken as zero.
                     cx_in   = 32'sd1073741824;
                     cy_in   = '0;
                     step_in = lcvg_pkg::OP_KR;
                  end
               end
               lcvg_pkg::OP_DIVY: begin
                  cx_in     = d_ff[0][31] ? -q_signed : q_signed;
                  dv_quo_in = {2'd0, lcvg_pkg::abs32(d_ff[1]), 30'd0};
                  dv_rem_in = '0;
                  dv_den_in = root;
                  iter_in   = 6'd63;
               end
               lcvg_pkg::OP_CY: cy_in = d_ff[1][31] ? -q_signed : q_signed;
               lcvg_pkg::OP_RDOT: rdot_in = lcvg_pkg::sat32(70'((-prod_ff) >>> 16));
               lcvg_pkg::OP_VX0: acc_in = 66'((-prod_ff) >>> 16);
               lcvg_pkg::OP_VX1: acc_in = acc_ff + 66'(prod_ff >>> 30);
               lcvg_pkg::OP_VY0: begin
                  vc_in[0] = lcvg_pkg::sat32(70'(acc_ff) + 70'(ov_ff[0]));
                  acc_in   = 66'(prod_ff >>> 16);
               end
               lcvg_pkg::OP_VY1: acc_in = acc_ff + 66'(prod_ff >>> 30);
               lcvg_pkg::OP_VZ: begin
                  vc_in[1] = lcvg_pkg::sat32(70'(acc_ff) + 70'(ov_ff[1]));
                  vc_in[2] = lcvg_pkg::sat32(70'((-prod_ff) >>> 16) + 70'(ov_ff[2]));
               end
               lcvg_pkg::OP_NY: acc_in = 66'(prod_ff);
               lcvg_pkg::OP_NZ: acc_in = acc_ff + 66'(prod_ff);
               lcvg_pkg::OP_CLIP0: begin
                  ax_in = 2'd0;
                  if (!clip_needed) step_in = lcvg_pkg::OP_NEXT;
               end
               lcvg_pkg::OP_CLIPD: begin
                  dv_quo_in = 64'(prod_ff);
                  dv_rem_in = '0;
                  dv_den_in = root;
                  iter_in   = 6'd63;
               end
               lcvg_pkg::OP_CLIPW: begin
                  vc_in[ax_ff] = vc_ff[ax_ff][31] ? -q_signed : q_signed;
                  if (ax_ff == 2'd2) begin
                     ax_in   = 2'd0;
                  end else begin
                     ax_in   = ax_ff + 2'd1;
                     step_in = lcvg_pkg::OP_CLIPM;
                  end
               end
               lcvg_pkg::OP_NEXT: begin
                  for (int i = 0; i < 3; i++) begin
                     if (pass_ff) v2_in[i] = vc_ff[i];
                     else         v1_in[i] = vc_ff[i];
                  end
                  ax_in = 2'd0;
                  if (!pass_ff) begin
                     pass_in = 1'b1;
                     step_in = lcvg_pkg::OP_DIFF;
                  end
               end
               lcvg_pkg::OP_BL1: acc_in = 66'(prod_ff);
               lcvg_pkg::OP_BL2: b_in = 33'((acc_ff + 66'(prod_ff)) >>> 16);
               lcvg_pkg::OP_BL4: begin
                  pose_in[ax_ff] = lcvg_pkg::sat32(70'(pose_ff[ax_ff]) +
                                                   70'(prod_ff >>> 24));
                  if (ax_ff != 2'd2) begin
                     ax_in   = ax_ff + 2'd1;
                     step_in = lcvg_pkg::OP_BL0;
                  end else begin
                     step_in = lcvg_pkg::OP_DIFF;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcvg_pkg::ST_IDLE;
         step_ff      <= lcvg_pkg::OP_DIFF;
         seeded_ff    <= 1'b0;
         pass_ff      <= 1'b0;
         ax_ff        <= 2'd0;
         iter_ff      <= 6'd0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) pose_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         seeded_ff    <= seeded_in;
         pass_ff      <= pass_in;
         ax_ff        <= ax_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 3; i++) pose_ff[i] <= pose_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < 3; i++) begin
            meas_ff[i] <= $signed(req_tdata[32*i +: 32]);
            cen_ff[i]  <= $signed(req_tdata[96 + 32*i +: 32]);
            ov_ff[i]   <= $signed(req_tdata[192 + 32*i +: 32]);
         end
      end
      for (int i = 0; i < 3; i++) begin
         d_ff[i]  <= d_in[i];
         vc_ff[i] <= vc_in[i];
         v1_ff[i] <= v1_in[i];
         v2_ff[i] <= v2_in[i];
      end
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      rdot_ff     <= rdot_in;
      b_ff        <= b_in;
      acc_ff      <= acc_in;
      sq_n_ff     <= sq_n_in;
      sq_res_ff   <= sq_res_in;
      sq_bit_ff   <= sq_bit_in;
      dv_rem_ff   <= dv_rem_in;
      dv_quo_ff   <= dv_quo_in;
      dv_den_ff   <= dv_den_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == lcvg_pkg::ST_DIV |-> dv_den_ff != 32'd0)
      else $error("divider running with a zero divisor");

   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      state_ff == lcvg_pkg::ST_FINISH && out_free |=> rsp_valid_ff && req_tready)
      else $error("finished result not presented");

   a_seed_on_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(seeded_ff) |-> $past(req_fire))
      else $error("pose seeded without an input transfer");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == lcvg_pkg::ST_SQRT |=> !req_tready)
      else $error("input taken while a square root is running");

endmodule
